// ===== sv/gcll_pkg.sv =====
package gcll_pkg;

    // field and register widths
    localparam int OBS_W        = 24;
    localparam int CNT_W        = 4;
    localparam int CFG_W        = 24;
    localparam int LNT_W        = 32;
    localparam int LL_W         = 32;
    localparam int MAX_DYES     = 15;
    localparam int NUM_CHANNELS = 3;

    // datapath widths
    localparam int MEAN_W = CFG_W + CNT_W;          // count * dye_mean
    localparam int VAR_W  = MEAN_W + 1;             // count * dye_variance + background
    localparam int ERR_W  = VAR_W + 1;              // signed obs - mean
    localparam int MAG_W  = VAR_W;                  // |err|
    localparam int SQ_W   = 2 * MAG_W;              // err^2, Q.16
    localparam int NUM_W  = SQ_W + 8;               // err^2 << 8
    localparam int QUO_W  = 64;                     // quotient bits produced
    localparam int TOP_W  = NUM_W - QUO_W;          // numerator bits above the quotient
    localparam int DIV_BITS  = 4;                   // quotient bits per step stage
    localparam int NUM_STEPS = QUO_W / DIV_BITS;    // also the log2 fraction bit count
    localparam int EXP_W  = 5;
    localparam int MANT_W = 31;                     // Q1.30 mantissa
    localparam int FRAC_W = NUM_STEPS;
    localparam int L2_W   = EXP_W + FRAC_W;
    localparam int LNP_W  = L2_W + 32 + 1;          // log2 * ln2 product plus rounding carry
    localparam int LN_W   = 24;
    localparam int TERM_W = 51;
    localparam int CHAN_W = TERM_W + 2;
    localparam int SUM_W  = CHAN_W + 2;

    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
    localparam int                LN256_Q16 = 363409;

    // front (2) + steps + tail (2)
    localparam int LAT_LANE = NUM_STEPS + 4;

    typedef enum logic [1:0] {
        REG_DYE_MEAN = 2'd0,
        REG_DYE_VAR  = 2'd1,
        REG_BG_VAR   = 2'd2,
        REG_LOG_NORM = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]        dye_mean;
        logic [CFG_W-1:0]        dye_variance;
        logic [CFG_W-1:0]        background_variance;
        logic signed [LNT_W-1:0] log_norm_term;
    } cfg_t;

    typedef struct packed {
        logic signed [OBS_W-1:0] obs_a;
        logic signed [OBS_W-1:0] obs_b;
        logic signed [OBS_W-1:0] obs_c;
        logic [CNT_W-1:0]        count_a;
        logic [CNT_W-1:0]        count_b;
        logic [CNT_W-1:0]        count_c;
    } in_t;

    typedef struct packed {
        logic signed [LL_W-1:0] log_likelihood;
        logic                   saturated;
    } out_t;

    typedef struct packed {
        logic signed [OBS_W-1:0] obs;
        logic [CNT_W-1:0]        count;
    } lane_in_t;

    // state carried through the divide / log2 step stages
    typedef struct packed {
        logic [VAR_W-1:0]  rem;
        logic [QUO_W-1:0]  nq;      // numerator bits shift out the top, quotient in the bottom
        logic [VAR_W-1:0]  var_q;
        logic              ovf;
        logic [MANT_W-1:0] x;
        logic [EXP_W-1:0]  e;
        logic [FRAC_W-1:0] frac;
    } step_t;

endpackage

// ===== sv/gcll_front.sv =====
module gcll_front (
    input  logic              aclk,
    input  logic              adv,
    input  gcll_pkg::cfg_t    cfg,
    input  gcll_pkg::lane_in_t din,
    output gcll_pkg::step_t   step_out
);
    import gcll_pkg::*;

    logic [CNT_W-1:0]          cnt;
    logic [MEAN_W-1:0]         mean;
    logic [VAR_W-1:0]          var_sum;
    logic [ERR_W-1:0]          err;
    logic [ERR_W-1:0]          mag_full;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [VAR_W-1:0]          var_reg, var_next;
    logic [SQ_W-1:0]           sq;
    logic [EXP_W-1:0]          e;
    logic [MANT_W+VAR_W-1:0]   sh;
    step_t                     f2_reg, f2_next;

    // stage 1: mean, variance, |error|
    always_comb begin
        cnt      = (din.count > CNT_W'(MAX_DYES)) ? CNT_W'(MAX_DYES) : din.count;
        mean     = cnt * cfg.dye_mean;
        var_sum  = cnt * cfg.dye_variance + cfg.background_variance;
        var_next = (var_sum == '0) ? VAR_W'(1) : var_sum;
        err      = {{(ERR_W-OBS_W){din.obs[OBS_W-1]}}, din.obs}
                 - {{(ERR_W-MEAN_W){1'b0}}, mean};
        mag_full = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;
        mag_next = mag_full[MAG_W-1:0];
    end

    // stage 2: square, divider setup, log2 normalization
    always_comb begin
        sq = mag_reg * mag_reg;
        e  = '0;
        for (int i = 0; i < VAR_W; i++) begin
            if (var_reg[i]) e = EXP_W'(i);
        end
        sh = {{MANT_W{1'b0}}, var_reg} << (MANT_W - 1 - int'(e));
        f2_next.rem   = VAR_W'(sq[SQ_W-1 -: TOP_W]);
        f2_next.nq    = {sq[SQ_W-TOP_W-1:0], 8'b0};
        f2_next.ovf   = VAR_W'(sq[SQ_W-1 -: TOP_W]) >= var_reg;
        f2_next.var_q = var_reg;
        f2_next.x     = sh[MANT_W-1:0];
        f2_next.e     = e;
        f2_next.frac  = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= mag_next;
            var_reg <= var_next;
            f2_reg  <= f2_next;
        end
    end

    assign step_out = f2_reg;

endmodule

// ===== sv/gcll_step.sv =====
module gcll_step (
    input  logic            aclk,
    input  logic            adv,
    input  gcll_pkg::step_t step_in,
    output gcll_pkg::step_t step_out
);
    import gcll_pkg::*;

    logic [VAR_W:0]      trial;
    logic [VAR_W-1:0]    rem;
    logic [QUO_W-1:0]    nq;
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     sqr;
    step_t               q_reg, q_next;

    always_comb begin
        rem = step_in.rem;
        nq  = step_in.nq;
        // restoring division, a few quotient bits
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem, nq[QUO_W-1]};
            nq    = {nq[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, step_in.var_q}) begin
                trial = trial - {1'b0, step_in.var_q};
                nq[0] = 1'b1;
            end
            rem = trial[VAR_W-1:0];
        end

        // one log2 fraction bit by squaring the mantissa
        prod = step_in.x * step_in.x;
        sqr  = prod[2*MANT_W-1:MANT_W-1];

        q_next       = step_in;
        q_next.rem   = rem;
        q_next.nq    = nq;
        q_next.x     = sqr[MANT_W] ? sqr[MANT_W:1] : sqr[MANT_W-1:0];
        q_next.frac  = {step_in.frac[FRAC_W-2:0], sqr[MANT_W]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg <= q_next;
        end
    end

    assign step_out = q_reg;

endmodule

// ===== sv/gcll_lane.sv =====
module gcll_lane (
    input  logic                              aclk,
    input  logic                              adv,
    input  gcll_pkg::cfg_t                    cfg,
    input  gcll_pkg::lane_in_t                din,
    output logic signed [gcll_pkg::CHAN_W-1:0] chan
);
    import gcll_pkg::*;

    step_t              chain [NUM_STEPS+1];
    logic [TERM_W-1:0]  term_reg, term_next;
    logic [LNP_W-1:0]   lnp_reg, lnp_next;
    logic [L2_W-1:0]    l2;
    logic               big;
    logic [LNP_W-1:0]   lnp_rnd;
    logic signed [LN_W-1:0]   ln;
    logic signed [CHAN_W-1:0] chan_reg, chan_next;

    gcll_front u_front (
        .aclk     (aclk),
        .adv      (adv),
        .cfg      (cfg),
        .din      (din),
        .step_out (chain[0])
    );

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        gcll_step u_step (
            .aclk     (aclk),
            .adv      (adv),
            .step_in  (chain[g]),
            .step_out (chain[g+1])
        );
    end

    // tail 1: cap the quadratic term, scale log2 by ln2
    always_comb begin
        big       = chain[NUM_STEPS].ovf | (|chain[NUM_STEPS].nq[QUO_W-1:TERM_W-1]);
        term_next = big ? TERM_CAP : chain[NUM_STEPS].nq[TERM_W-1:0];
        l2        = {chain[NUM_STEPS].e, chain[NUM_STEPS].frac};
        lnp_next  = LNP_W'(l2) * LNP_W'(LN2_Q32);
    end

    // tail 2: round, remove ln(256), add
    always_comb begin
        lnp_rnd   = lnp_reg + (LNP_W'(1) << 31);
        ln        = $signed({{(LN_W-(LNP_W-32)){1'b0}}, lnp_rnd[LNP_W-1:32]})
                  - $signed(LN_W'(LN256_Q16));
        chan_next = $signed({2'b00, term_reg})
                  + $signed({{(CHAN_W-LN_W){ln[LN_W-1]}}, ln});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term_next;
            lnp_reg  <= lnp_next;
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== sv/gaussian_count_log_likelihood.sv =====
// Gaussian count log-likelihood scorer, three channels, diagonal covariance.
// Input channel (s_valid/s_ready/s_payload): three signed Q16.8 intensities
// and three 4-bit dye counts per request. Result channel (m_valid/m_ready/
// m_payload): signed Q15.16 log-likelihood plus a saturation flag, one
// result per request, in order.
// Config port (cfg_we/cfg_index/cfg_wdata): single-cycle writes of
// dye_mean, dye_variance, background_variance, log_norm_term. Write only
// while no request is in flight.
// Throughput: one request per cycle unless stalled. From accept to m_valid a
// request passes the front registers, the 16-stage divide/log2 pipeline (4
// quotient bits and one mantissa squaring per stage), tail, sum and output registers.
// Reset (aresetn low, synchronous): config returns to 1.0/1.0/1.0/0, all
// valid bits clear; data registers are not reset.
// Stall: the whole pipeline holds while the output register is full and
// m_ready is low; s_ready drops in the same cycle, so nothing is lost.
module gaussian_count_log_likelihood (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gcll_pkg::in_t        s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gcll_pkg::out_t       m_payload,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);
    import gcll_pkg::*;

    localparam int LAT = LAT_LANE + 1;   // lanes plus channel sum

    localparam logic signed [SUM_W-1:0] LL_MAX = {{(SUM_W-LL_W+1){1'b0}}, {(LL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] LL_MIN = {{(SUM_W-LL_W+1){1'b1}}, {(LL_W-1){1'b0}}};

    cfg_t                     cfg_reg, cfg_next;
    logic                     adv;
    logic [LAT-1:0]           v_reg, v_next;
    logic                     m_valid_reg, m_valid_next;
    lane_in_t                 lane_in [NUM_CHANNELS];
    logic signed [CHAN_W-1:0] chan [NUM_CHANNELS];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  adj, half, val;
    out_t                     out_reg, out_next;

    // single global advance: pipeline moves unless the output is blocked
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // config writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_DYE_MEAN: cfg_next.dye_mean            = cfg_wdata[CFG_W-1:0];
                REG_DYE_VAR:  cfg_next.dye_variance        = cfg_wdata[CFG_W-1:0];
                REG_BG_VAR:   cfg_next.background_variance = cfg_wdata[CFG_W-1:0];
                REG_LOG_NORM: cfg_next.log_norm_term       = $signed(cfg_wdata[LNT_W-1:0]);
            endcase
        end
    end

    assign lane_in[0] = '{obs: s_payload.obs_a, count: s_payload.count_a};
    assign lane_in[1] = '{obs: s_payload.obs_b, count: s_payload.count_b};
    assign lane_in[2] = '{obs: s_payload.obs_c, count: s_payload.count_c};

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        gcll_lane u_lane (
            .aclk (aclk),
            .adv  (adv),
            .cfg  (cfg_reg),
            .din  (lane_in[g]),
            .chan (chan[g])
        );
    end

    // sum of the per-channel terms
    always_comb begin
        sum_next = '0;
        for (int j = 0; j < NUM_CHANNELS; j++) begin
            sum_next = sum_next + $signed({{(SUM_W-CHAN_W){chan[j][CHAN_W-1]}}, chan[j]});
        end
    end

    // -(sum/2) with truncation toward zero, minus the norm term, then clamp
    always_comb begin
        adj  = sum_reg + $signed({{(SUM_W-1){1'b0}}, sum_reg[SUM_W-1]});
        half = adj >>> 1;
        val  = -half - $signed({{(SUM_W-LNT_W){cfg_reg.log_norm_term[LNT_W-1]}},
                                cfg_reg.log_norm_term});
        priority if (val > LL_MAX) begin
            out_next.log_likelihood = LL_MAX[LL_W-1:0];
            out_next.saturated      = 1'b1;
        end else if (val < LL_MIN) begin
            out_next.log_likelihood = LL_MIN[LL_W-1:0];
            out_next.saturated      = 1'b1;
        end else begin
            out_next.log_likelihood = val[LL_W-1:0];
            out_next.saturated      = 1'b0;
        end
    end

    assign v_next       = {v_reg[LAT-2:0], s_valid};
    assign m_valid_next = v_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dye_mean            <= CFG_W'(256);
            cfg_reg.dye_variance        <= CFG_W'(256);
            cfg_reg.background_variance <= CFG_W'(256);
            cfg_reg.log_norm_term       <= '0;
            v_reg                       <= '0;
            m_valid_reg                 <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            if (adv) begin
                v_reg       <= v_next;
                m_valid_reg <= m_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
            out_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gcll_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_payload;
    logic       m_valid;
    logic       m_ready;
    out_t       m_payload;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_wdata;

    gaussian_count_log_likelihood u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // local copy of the scorer registers
    longint unsigned mu_reg;
    longint unsigned dvar_reg;
    longint unsigned bgvar_reg;
    longint          lnorm_reg;

    out_t score_q[$];     // predicted scores, oldest first
    int   err_cnt;
    int   burst_left;     // requests left in the current sender burst
    bit   rx_stall_on;    // receiver stall pattern enable

    // ln(v/256) in Q.16 from log2 by repeated squaring of a Q1.30 mantissa
    function automatic longint ln_q16(longint unsigned v);
        int unsigned     e;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned l2;
        e = 0;
        frac = 0;
        while (e < 40 && (v >> (e + 1)) != 0)
            e++;
        x = v << (30 - e);
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac = frac | 1;
            end
        end
        l2 = (longint'(e) << 16) + frac;
        return longint'((l2 * 64'd2977044472 + (64'd1 << 31)) >> 32) - 363409;
    endfunction

    function automatic out_t score_request(in_t req);
        longint          obs[3];
        longint unsigned cnt[3];
        longint          sum;
        longint          mean;
        longint          err;
        longint          val;
        longint unsigned vr;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned q;
        longint unsigned r;
        longint unsigned term;
        out_t            res;
        obs[0] = longint'(req.obs_a);
        obs[1] = longint'(req.obs_b);
        obs[2] = longint'(req.obs_c);
        cnt[0] = req.count_a;
        cnt[1] = req.count_b;
        cnt[2] = req.count_c;
        sum = 0;
        for (int j = 0; j < 3; j++) begin
            if (cnt[j] > MAX_DYES)
                cnt[j] = MAX_DYES;
            mean = longint'(cnt[j] * mu_reg);
            vr = cnt[j] * dvar_reg + bgvar_reg;
            if (vr == 0)
                vr = 1;     // zero variance counts as one LSB
            err = obs[j] - mean;
            mag = (err < 0) ? -err : err;
            sq = mag * mag;
            q = sq / vr;
            r = sq % vr;
            // huge quadratic term is capped
            if (q >= (64'd1 << 42))
                term = 64'd1 << 50;
            else
                term = q * 256 + (r * 256) / vr;
            sum += longint'(term) + ln_q16(vr);
        end
        val = -(sum / 2) - lnorm_reg;
        res.saturated = 1'b0;
        if (val > 64'sd2147483647) begin
            val = 64'sd2147483647;
            res.saturated = 1'b1;
        end else if (val < -64'sd2147483648) begin
            val = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.log_likelihood = val[31:0];
        return res;
    endfunction

    // accepted requests -> predicted scores
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            score_q.push_back(score_request(s_payload));
    end

    // result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                $display("%0t: unexpected result ll=%0d sat=%0b", $realtime,
                         m_payload.log_likelihood, m_payload.saturated);
                err_cnt++;
            end else begin
                want = score_q.pop_front();
                if (m_payload.log_likelihood !== want.log_likelihood) begin
                    $display("%0t: log_likelihood expected %0d actual %0d", $realtime,
                             want.log_likelihood, m_payload.log_likelihood);
                    err_cnt++;
                end
                if (m_payload.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b", $realtime,
                             want.saturated, m_payload.saturated);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: stall stretches of random length, off during reset and some phases
    always @(negedge aclk) begin
        if (!rx_stall_on || !aresetn)
            m_ready <= 1'b1;
        else if ($urandom_range(0, 15) == 0)
            m_ready <= ~m_ready;
        else if (!m_ready && $urandom_range(0, 3) == 0)
            m_ready <= 1'b1;
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_DYE_MEAN: mu_reg = val[23:0];
            REG_DYE_VAR:  dvar_reg = val[23:0];
            REG_BG_VAR:   bgvar_reg = val[23:0];
            REG_LOG_NORM: lnorm_reg = longint'(signed'(val));
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // send one request; bursts end with a random gap
    task automatic send_req(in_t req);
        s_payload = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // wait until every score has come back, then idle past the pipeline depth
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (score_q.size() != 0)
            @(negedge aclk);
        repeat (LAT_LANE + 12) @(negedge aclk);
    endtask

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607)
            return 24'h7FFFFF;
        if (v < -8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    // observation near the hypothesized mean, so scores stay mostly in range
    function automatic logic [23:0] near_obs(logic [3:0] cnt);
        longint spread;
        spread = longint'(dvar_reg) * cnt + bgvar_reg;
        spread = (spread < 4096) ? 4096 : spread;
        return clip24(longint'(cnt * mu_reg)
                      + longint'($urandom_range(0, 2 * 4096)) - 4096
                      + (($urandom_range(0, 1) == 1) ? longint'($urandom_range(0, 255)) : 0));
    endfunction

    function automatic in_t rand_req(bit well_formed);
        in_t req;
        req.count_a = CNT_W'($urandom_range(0, 15));
        req.count_b = CNT_W'($urandom_range(0, 15));
        req.count_c = CNT_W'($urandom_range(0, 15));
        if (well_formed) begin
            req.obs_a = near_obs(req.count_a);
            req.obs_b = near_obs(req.count_b);
            req.obs_c = near_obs(req.count_c);
        end else begin
            req.obs_a = OBS_W'($urandom);
            req.obs_b = OBS_W'($urandom);
            req.obs_c = OBS_W'($urandom);
        end
        return req;
    endfunction

    function automatic in_t make_req(logic [23:0] oa, logic [23:0] ob, logic [23:0] oc,
                                     logic [3:0] ca, logic [3:0] cb, logic [3:0] cc);
        in_t req;
        req.obs_a = oa;
        req.obs_b = ob;
        req.obs_c = oc;
        req.count_a = ca;
        req.count_b = cb;
        req.count_c = cc;
        return req;
    endfunction

    // field extremes at reset settings
    task automatic test_field_extremes();
        send_req(make_req(24'h0, 24'h0, 24'h0, 4'd0, 4'd0, 4'd0));
        send_req(make_req(24'h000100, 24'h000200, 24'h000F00, 4'd1, 4'd2, 4'd15));
        send_req(make_req(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 4'd15, 4'd15, 4'd0));
        send_req(make_req(24'h800000, 24'h7FFFFF, 24'h800000, 4'd0, 4'd15, 4'd15));
        send_req(make_req(24'hFFFFFF, 24'h000001, 24'hFFFF00, 4'd8, 4'd7, 4'd1));
        drain();
    endtask

    // register extremes, including a variance of one LSB and huge error terms
    task automatic test_register_extremes();
        write_reg(REG_DYE_MEAN, 32'h0);
        write_reg(REG_DYE_VAR, 32'h0);
        write_reg(REG_BG_VAR, 32'h1);
        write_reg(REG_LOG_NORM, 32'h0);
        send_req(make_req(24'h7FFFFF, 24'h800000, 24'h0, 4'd3, 4'd0, 4'd15));
        send_req(make_req(24'h0, 24'h0, 24'h0, 4'd15, 4'd15, 4'd15));
        send_req(make_req(24'h000010, 24'hFFFFF0, 24'h000001, 4'd1, 4'd2, 4'd3));
        drain();
        write_reg(REG_DYE_MEAN, 32'hFFFFFF);
        write_reg(REG_DYE_VAR, 32'hFFFFFF);
        write_reg(REG_BG_VAR, 32'hFFFFFF);
        write_reg(REG_LOG_NORM, 32'h80000000);
        send_req(make_req(24'h7FFFFF, 24'h800000, 24'h0, 4'd15, 4'd15, 4'd15));
        send_req(make_req(24'h0, 24'h0, 24'h0, 4'd0, 4'd0, 4'd0));
        send_req(make_req(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'd1, 4'd0, 4'd2));
        drain();
        write_reg(REG_LOG_NORM, 32'h7FFFFFFF);
        write_reg(REG_DYE_MEAN, 32'h000080);
        send_req(make_req(24'h0, 24'h0, 24'h0, 4'd0, 4'd0, 4'd0));
        send_req(make_req(24'h800000, 24'h800000, 24'h800000, 4'd15, 4'd15, 4'd15));
        send_req(make_req(24'h000780, 24'h000080, 24'h000100, 4'd15, 4'd1, 4'd2));
        drain();
    endtask

    // random phases over several settings; one phase without receiver stalls
    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            rx_stall_on = (ph != 3);
            write_reg(REG_DYE_MEAN, $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                                          : $urandom_range(16, 4096));
            write_reg(REG_DYE_VAR, $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                                         : $urandom_range(0, 2048));
            write_reg(REG_BG_VAR, $urandom_range(0, 1) ? $urandom_range(1, 24'hFFFFFF)
                                                        : $urandom_range(1, 1024));
            write_reg(REG_LOG_NORM, $urandom_range(0, 1) ? $urandom
                                                          : $urandom_range(0, 20'hFFFFF));
            for (int n = 0; n < 105; n++) begin
                send_req(rand_req($urandom_range(0, 3) != 0));
                // in phase 2, after the 51st request, the sender holds off until every score is back
                if (n == 50 && ph == 2)
                    drain();
            end
            drain();
        end
        rx_stall_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DYE_MEAN;
        cfg_wdata = '0;
        err_cnt = 0;
        burst_left = 0;
        rx_stall_on = 1'b1;
        mu_reg = 256;
        dvar_reg = 256;
        bgvar_reg = 256;
        lnorm_reg = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_register_extremes();
        test_random_phases();

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
